// ===== rtl/cpct_pkg.sv =====
`timescale 1ns / 1ps

package cpct_pkg;

  localparam int unsigned CODE_W     = 5;
  localparam int unsigned PEND_W     = 7;
  localparam int unsigned CNT_W      = 3;
  localparam int unsigned MAX_LEN    = 8;
  localparam int unsigned TABLE_SIZE = 32;
  localparam int unsigned RES_DEPTH  = 3;
  localparam int unsigned RES_IDX_W  = 2;

  localparam logic [6:0] NEWLINE_CHAR = 7'd10;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] char_byte;
  } item_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       line_done;
    logic       last;
  } result_t;

  typedef struct packed {
    logic              hit;
    logic [CODE_W-1:0] code;
  } char_code_t;

  typedef struct packed {
    logic       hit;
    logic [6:0] ch;
  } match_t;

  localparam logic [3:0] CODE_LEN [TABLE_SIZE] = '{
    4'd3, 4'd6, 4'd6, 4'd8, 4'd6, 4'd6, 4'd6, 4'd8,
    4'd4, 4'd4, 4'd3, 4'd5, 4'd8, 4'd6, 4'd4, 4'd8,
    4'd4, 4'd5, 4'd8, 4'd8, 4'd5, 4'd3, 4'd8, 4'd4,
    4'd5, 4'd5, 4'd8, 4'd8, 4'd6, 4'd8, 4'd8, 4'd8
  };

  localparam logic [7:0] CODE_BITS [TABLE_SIZE] = '{
    8'h05, 8'h00, 8'h03, 8'h91, 8'h11, 8'h01, 8'h25, 8'h9A,
    8'h05, 8'h01, 8'h06, 8'h09, 8'h9B, 8'h10, 8'h07, 8'h98,
    8'h06, 8'h04, 8'h99, 8'h9E, 8'h05, 8'h07, 8'h9F, 8'h08,
    8'h06, 8'h07, 8'h9C, 8'h9D, 8'h02, 8'h92, 8'h93, 8'h90
  };

  localparam logic [6:0] CODE_CHAR [TABLE_SIZE] = '{
    7'h20, 7'h27, 7'h2C, 7'h2D, 7'h2E, 7'h3F, 7'h41, 7'h42,
    7'h43, 7'h44, 7'h45, 7'h46, 7'h47, 7'h48, 7'h49, 7'h4A,
    7'h4B, 7'h4C, 7'h4D, 7'h4E, 7'h4F, 7'h50, 7'h51, 7'h52,
    7'h53, 7'h54, 7'h55, 7'h56, 7'h57, 7'h58, 7'h59, 7'h5A
  };

  function automatic char_code_t char_code(input logic [7:0] b);
    char_code_t r;
    r.hit  = 1'b1;
    r.code = '0;
    if (b >= 8'h41 && b <= 8'h5A) begin
      r.code = CODE_W'(b - 8'h41);
    end else begin
      case (b)
        8'h20:   r.code = 5'd26;
        8'h2E:   r.code = 5'd27;
        8'h2C:   r.code = 5'd28;
        8'h2D:   r.code = 5'd29;
        8'h27:   r.code = 5'd30;
        8'h3F:   r.code = 5'd31;
        default: r.hit  = 1'b0;
      endcase
    end
    return r;
  endfunction

  function automatic match_t lookup(input logic [7:0] bits, input logic [3:0] len);
    match_t r;
    r.hit = 1'b0;
    r.ch  = '0;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      if (CODE_LEN[i] == len && CODE_BITS[i] == bits) begin
        r.hit = 1'b1;
        r.ch  = CODE_CHAR[i];
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/char_to_prefix_code_translator_unit.sv =====
`timescale 1ns / 1ps

// Character to prefix code translator.
// Input channel (item_valid / item_stall / item): one transfer per character
// byte (mode 0) or end-of-line marker (mode 1). Output channel (result_valid /
// result_stall / result): decoded ASCII characters, last set on the final
// result of each input, and a single newline result with line_done on mode 1.
// Items are handled one at a time; item_stall is high while one is in work.
// A mapped byte is accepted, its five code bits then pass the bit-serial
// matcher one per cycle, and its 0 to 2 results follow, one per cycle while
// the receiver does not stall. An unmapped byte is accepted and yields
// nothing; an end-of-line item goes straight to its single result.
// The shift phase runs the single-bit prefix match loop once per code bit.
// While result_stall is high the current result holds and nothing advances.
// Reset empties the pending bit prefix and returns the block to idle.
module char_to_prefix_code_translator_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  cpct_pkg::item_t      item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output cpct_pkg::result_t    result
);

  cpct_pkg::state_t state, state_next;

  logic [cpct_pkg::CODE_W-1:0]    code_sr, code_sr_next;
  logic [2:0]                     bit_cnt, bit_cnt_next;
  logic [cpct_pkg::PEND_W-1:0]    pending_bits, pending_bits_next;
  logic [cpct_pkg::CNT_W-1:0]     pending_count, pending_count_next;
  logic [6:0]                     res_char [cpct_pkg::RES_DEPTH];
  logic [6:0]                     res_char_next [cpct_pkg::RES_DEPTH];
  logic [cpct_pkg::RES_IDX_W-1:0] res_count, res_count_next;
  logic [cpct_pkg::RES_IDX_W-1:0] res_idx, res_idx_next;
  logic                           line_flag, line_flag_next;

  logic [7:0]           probe_bits;
  logic [3:0]           probe_len;
  cpct_pkg::match_t    match;
  cpct_pkg::char_code_t cc;

  assign probe_bits = {pending_bits, code_sr[cpct_pkg::CODE_W-1]};
  assign probe_len  = {1'b0, pending_count} + 4'd1;
  assign match      = cpct_pkg::lookup(probe_bits, probe_len);
  assign cc         = cpct_pkg::char_code(item.char_byte);

  assign item_stall       = (state != cpct_pkg::ST_IDLE);
  assign result_valid     = (state == cpct_pkg::ST_EMIT);
  assign result.out_char  = res_char[res_idx];
  assign result.line_done = line_flag;
  assign result.last      = (res_idx == res_count - 2'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= cpct_pkg::ST_IDLE;
      pending_bits  <= '0;
      pending_count <= '0;
      bit_cnt       <= '0;
      res_count     <= '0;
      res_idx       <= '0;
      line_flag     <= 1'b0;
    end else begin
      state         <= state_next;
      pending_bits  <= pending_bits_next;
      pending_count <= pending_count_next;
      bit_cnt       <= bit_cnt_next;
      res_count     <= res_count_next;
      res_idx       <= res_idx_next;
      line_flag     <= line_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    code_sr  <= code_sr_next;
    res_char <= res_char_next;
  end

  always_comb begin
    state_next         = state;
    code_sr_next       = code_sr;
    bit_cnt_next       = bit_cnt;
    pending_bits_next  = pending_bits;
    pending_count_next = pending_count;
    res_char_next      = res_char;
    res_count_next     = res_count;
    res_idx_next       = res_idx;
    line_flag_next     = line_flag;
    case (state)
      cpct_pkg::ST_IDLE: begin
        res_idx_next = '0;
        if (item_valid) begin
          if (item.mode) begin
            pending_bits_next  = '0;
            pending_count_next = '0;
            res_char_next[0]   = cpct_pkg::NEWLINE_CHAR;
            res_count_next     = 2'd1;
            line_flag_next     = 1'b1;
            state_next         = cpct_pkg::ST_EMIT;
          end else if (cc.hit) begin
            code_sr_next   = cc.code;
            bit_cnt_next   = '0;
            res_count_next = '0;
            line_flag_next = 1'b0;
            state_next     = cpct_pkg::ST_SHIFT;
          end
        end
      end
      cpct_pkg::ST_SHIFT: begin
        code_sr_next = {code_sr[cpct_pkg::CODE_W-2:0], 1'b0};
        bit_cnt_next = bit_cnt + 3'd1;
        if (match.hit) begin
          pending_bits_next  = '0;
          pending_count_next = '0;
          if (res_count < 2'(cpct_pkg::RES_DEPTH)) begin
            res_char_next[res_count] = match.ch;
            res_count_next           = res_count + 2'd1;
          end
        end else if (probe_len >= 4'(cpct_pkg::MAX_LEN)) begin
          pending_bits_next  = '0;
          pending_count_next = '0;
        end else begin
          pending_bits_next  = probe_bits[cpct_pkg::PEND_W-1:0];
          pending_count_next = probe_len[cpct_pkg::CNT_W-1:0];
        end
        if (bit_cnt == 3'(cpct_pkg::CODE_W - 1)) begin
          state_next = (res_count_next != '0) ? cpct_pkg::ST_EMIT : cpct_pkg::ST_IDLE;
        end
      end
      cpct_pkg::ST_EMIT: begin
        if (!result_stall) begin
          if (result.last) begin
            state_next = cpct_pkg::ST_IDLE;
          end else begin
            res_idx_next = res_idx + 2'd1;
          end
        end
      end
      default: state_next = cpct_pkg::ST_IDLE;
    endcase
  end

  // one item in work at a time
  a_no_accept_while_emitting: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> item_stall)
    else $error("input accepted while results pending");

  a_emit_has_results: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (res_count != '0) && (res_idx < res_count))
    else $error("result index out of range");

  a_eol_clears_prefix: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.line_done) |-> (pending_bits == '0) && (pending_count == '0))
    else $error("pending prefix kept over end of line");

  a_eol_single: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.line_done) |-> result.last && (res_count == 2'd1))
    else $error("end of line must be a single result");

endmodule
